// ===== design/drs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants for the dependency-ready scheduler.
// -----------------------------------------------------------------------------
package drs_pkg;

   localparam int NODE_SLOTS_DEF   = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int ACTION_BITS      = 2;
   localparam int SLOT_FIELD_BITS  = 4;
   localparam int PAY_FIELD_BITS   = 32;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_ADD_NODE = 2'd0,
      ACT_ADD_EDGE = 2'd1,
      ACT_NEXT     = 2'd2,
      ACT_REMOVE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_WR,
      ST_SCAN,
      ST_FETCH,
      ST_CLEAR
   } state_type;

   // payload memory port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } pay_ctl_type;

   // end of one transfer's work
   typedef struct packed {
      logic done;
      logic found;
   } finish_type;

endpackage : drs_pkg
`default_nettype wire

// ===== design/drs_deps.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// drs_deps
// Dependency row memory: one row per slot, one read and one write a cycle.
// Per-row valid flags make unwritten rows read as zero after reset.
// -----------------------------------------------------------------------------
module drs_deps import drs_pkg::*; #(
   parameter  int NODE_SLOTS = NODE_SLOTS_DEF,
   localparam int SLOT_BITS  = $clog2(NODE_SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [SLOT_BITS-1:0]  rd_addr,
   output logic [NODE_SLOTS-1:0] rd_row,
   input  logic                  wr_en,
   input  logic [SLOT_BITS-1:0]  wr_addr,
   input  logic [NODE_SLOTS-1:0] wr_row
);

   logic [NODE_SLOTS-1:0] mem [NODE_SLOTS];
   logic [NODE_SLOTS-1:0] rd_data_ff;
   logic [NODE_SLOTS-1:0] row_valid_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule : drs_deps
`default_nettype wire

// ===== design/drs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// drs_ctrl
// Sequencer: decodes actions, holds presence and handed-out flags, walks the
// dependency rows for next and remove, drives both memories.
// -----------------------------------------------------------------------------
module drs_ctrl import drs_pkg::*; #(
   parameter  int NODE_SLOTS   = NODE_SLOTS_DEF,
   parameter  int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   localparam int SLOT_BITS    = $clog2(NODE_SLOTS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_BITS-1:0]     action,
   input  logic [SLOT_FIELD_BITS-1:0] node_slot,
   input  logic [SLOT_FIELD_BITS-1:0] dependent_slot,
   input  logic [PAY_FIELD_BITS-1:0]  node_payload,
   input  logic [PAY_FIELD_BITS-1:0]  dependent_payload,
   output logic                       dep_rd_en,
   output logic [SLOT_BITS-1:0]       dep_rd_addr,
   input  logic [NODE_SLOTS-1:0]      dep_rd_row,
   output logic                       dep_wr_en,
   output logic [SLOT_BITS-1:0]       dep_wr_addr,
   output logic [NODE_SLOTS-1:0]      dep_wr_row,
   output pay_ctl_type                pay_ctl,
   output logic [SLOT_BITS-1:0]       pay_addr,
   output logic [PAYLOAD_BITS-1:0]    pay_wr_data,
   output finish_type                 finish,
   output logic [SLOT_BITS-1:0]       finish_slot
);

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NODE_SLOTS - 1);

   state_type               state_ff, state_in;
   logic [SLOT_BITS-1:0]    idx_ff, idx_in;
   logic [SLOT_BITS-1:0]    src_ff, dep_ff;
   logic [PAYLOAD_BITS-1:0] dep_pay_ff;
   logic [NODE_SLOTS-1:0]   present_ff, present_in;
   logic [NODE_SLOTS-1:0]   handed_ff, handed_in;

   action_type              act;
   logic                    accept;
   logic                    src_ok, dep_ok;
   logic [SLOT_BITS-1:0]    src_idx, dep_idx;
   logic [NODE_SLOTS-1:0]   src_bit_in, dep_bit_in, src_bit_ff, idx_bit;
   logic                    cand, last;

   assign act     = action_type'(action);
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign src_ok  = int'(node_slot) < NODE_SLOTS;
   assign dep_ok  = int'(dependent_slot) < NODE_SLOTS;
   assign src_idx = SLOT_BITS'(node_slot);
   assign dep_idx = SLOT_BITS'(dependent_slot);

   assign src_bit_in = NODE_SLOTS'(1) << src_idx;
   assign dep_bit_in = NODE_SLOTS'(1) << dep_idx;
   assign src_bit_ff = NODE_SLOTS'(1) << src_ff;
   assign idx_bit    = NODE_SLOTS'(1) << idx_ff;

   // row idx_ff is ready when present, not yet handed out and waiting on none
   assign cand = present_ff[idx_ff] && !handed_ff[idx_ff] && (dep_rd_row == '0);
   assign last = (idx_ff == LAST_SLOT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (act)
                  ACT_ADD_NODE: state_in = ST_IDLE;
                  ACT_ADD_EDGE: state_in = (src_ok && dep_ok) ? ST_EDGE_WR : ST_IDLE;
                  ACT_NEXT:     state_in = ST_SCAN;
                  ACT_REMOVE:   state_in = src_ok ? ST_CLEAR : ST_IDLE;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_EDGE_WR: state_in = ST_IDLE;
         ST_SCAN: begin
            if (cand) begin
               state_in = ST_FETCH;
            end else if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: state_in = ST_IDLE;
         ST_CLEAR: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory commands and completion
   always_comb begin
      dep_rd_en   = 1'b0;
      dep_rd_addr = '0;
      dep_wr_en   = 1'b0;
      dep_wr_addr = idx_ff;
      dep_wr_row  = '0;
      pay_ctl     = '0;
      pay_addr    = src_idx;
      pay_wr_data = PAYLOAD_BITS'(node_payload);
      finish      = '0;
      finish_slot = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (act)
                  ACT_ADD_NODE: begin
                     pay_ctl.wr_en = src_ok;
                     finish.done   = 1'b1;
                  end
                  ACT_ADD_EDGE: begin
                     if (src_ok && dep_ok) begin
                        pay_ctl.wr_en = 1'b1;
                        dep_rd_en     = 1'b1;
                        dep_rd_addr   = dep_idx;
                     end else begin
                        finish.done = 1'b1;
                     end
                  end
                  ACT_NEXT: begin
                     dep_rd_en = 1'b1;
                  end
                  ACT_REMOVE: begin
                     if (src_ok) begin
                        dep_rd_en = 1'b1;
                     end else begin
                        finish.done = 1'b1;
                     end
                  end
                  default: finish.done = 1'b1;
               endcase
            end
         end
         ST_EDGE_WR: begin
            // dependent payload goes last so a self edge keeps it
            pay_ctl.wr_en = 1'b1;
            pay_addr      = dep_ff;
            pay_wr_data   = dep_pay_ff;
            dep_wr_en     = 1'b1;
            dep_wr_addr   = dep_ff;
            dep_wr_row    = dep_rd_row | src_bit_ff;
            finish.done   = 1'b1;
         end
         ST_SCAN: begin
            if (cand) begin
               pay_ctl.rd_en = 1'b1;
               pay_addr      = idx_ff;
            end else if (last) begin
               finish.done = 1'b1;
            end else begin
               dep_rd_en   = 1'b1;
               dep_rd_addr = SLOT_BITS'(idx_ff + 1'b1);
            end
         end
         ST_FETCH: begin
            finish.done  = 1'b1;
            finish.found = 1'b1;
         end
         ST_CLEAR: begin
            dep_wr_en  = 1'b1;
            dep_wr_row = (idx_ff == src_ff) ? '0 : (dep_rd_row & ~src_bit_ff);
            if (last) begin
               finish.done = 1'b1;
            end else begin
               dep_rd_en   = 1'b1;
               dep_rd_addr = SLOT_BITS'(idx_ff + 1'b1);
            end
         end
         default: ;
      endcase
   end

   // flag and counter updates
   always_comb begin
      present_in = present_ff;
      handed_in  = handed_ff;
      idx_in     = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               unique case (act)
                  ACT_ADD_NODE: begin
                     if (src_ok) present_in = present_ff | src_bit_in;
                  end
                  ACT_ADD_EDGE: begin
                     if (src_ok && dep_ok) present_in = present_ff | src_bit_in | dep_bit_in;
                  end
                  ACT_REMOVE: begin
                     if (src_ok) begin
                        present_in = present_ff & ~src_bit_in;
                        handed_in  = handed_ff & ~src_bit_in;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (cand) begin
               handed_in = handed_ff | idx_bit;
            end else if (!last) begin
               idx_in = SLOT_BITS'(idx_ff + 1'b1);
            end
         end
         ST_CLEAR: begin
            if (!last) idx_in = SLOT_BITS'(idx_ff + 1'b1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         present_ff <= '0;
         handed_ff  <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         handed_ff  <= handed_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff     <= src_idx;
         dep_ff     <= dep_idx;
         dep_pay_ff <= PAYLOAD_BITS'(dependent_payload);
      end
   end

endmodule : drs_ctrl
`default_nettype wire

// ===== design/dependency_ready_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dependency_ready_scheduler
// Task scheduler over a fixed set of node slots with dependency edges.
// -----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  request   start/busy, req_action, req_*_slot,      start && !busy
//            req_*_payload
//  response  rsp_strobe, rsp_found, rsp_ready_slot,   rsp_strobe (one cycle)
//            rsp_ready_payload
//
//  Add node: done in the accept cycle, busy stays low. Add edge: a
//  dependency row read-modify-write. Next: one dependency row per cycle
//  through the row memory read port, plus a payload fetch on a hit.
//  Remove: one row read and written back per cycle. The response is
//  registered and shows in the cycle after the work ends. Synchronous
//  reset clears flags at once; no clearing pass. The receiver cannot
//  stall the response.
// -----------------------------------------------------------------------------
module dependency_ready_scheduler import drs_pkg::*; #(
   parameter  int NODE_SLOTS   = NODE_SLOTS_DEF,
   parameter  int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_BITS-1:0]     req_action,
   input  logic [SLOT_FIELD_BITS-1:0] req_node_slot,
   input  logic [SLOT_FIELD_BITS-1:0] req_dependent_slot,
   input  logic [PAY_FIELD_BITS-1:0]  req_node_payload,
   input  logic [PAY_FIELD_BITS-1:0]  req_dependent_payload,
   output logic                       rsp_strobe,
   output logic                       rsp_found,
   output logic [SLOT_FIELD_BITS-1:0] rsp_ready_slot,
   output logic [PAY_FIELD_BITS-1:0]  rsp_ready_payload
);

   localparam int SLOT_BITS = $clog2(NODE_SLOTS);

   logic                    dep_rd_en, dep_wr_en;
   logic [SLOT_BITS-1:0]    dep_rd_addr, dep_wr_addr;
   logic [NODE_SLOTS-1:0]   dep_rd_row, dep_wr_row;
   pay_ctl_type             pay_ctl;
   logic [SLOT_BITS-1:0]    pay_addr;
   logic [PAYLOAD_BITS-1:0] pay_wr_data;
   finish_type              finish;
   logic [SLOT_BITS-1:0]    finish_slot;

   // payload memory, read data registered
   logic [PAYLOAD_BITS-1:0] pay_mem [NODE_SLOTS];
   logic [PAYLOAD_BITS-1:0] pay_rd_ff;

   // response register
   logic                       rsp_strobe_ff;
   logic                       rsp_found_ff;
   logic [SLOT_FIELD_BITS-1:0] rsp_slot_ff;
   logic [PAY_FIELD_BITS-1:0]  rsp_payload_ff;

   drs_ctrl #(
      .NODE_SLOTS   (NODE_SLOTS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .action            (req_action),
      .node_slot         (req_node_slot),
      .dependent_slot    (req_dependent_slot),
      .node_payload      (req_node_payload),
      .dependent_payload (req_dependent_payload),
      .dep_rd_en         (dep_rd_en),
      .dep_rd_addr       (dep_rd_addr),
      .dep_rd_row        (dep_rd_row),
      .dep_wr_en         (dep_wr_en),
      .dep_wr_addr       (dep_wr_addr),
      .dep_wr_row        (dep_wr_row),
      .pay_ctl           (pay_ctl),
      .pay_addr          (pay_addr),
      .pay_wr_data       (pay_wr_data),
      .finish            (finish),
      .finish_slot       (finish_slot)
   );

   drs_deps #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_deps (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (dep_rd_en),
      .rd_addr (dep_rd_addr),
      .rd_row  (dep_rd_row),
      .wr_en   (dep_wr_en),
      .wr_addr (dep_wr_addr),
      .wr_row  (dep_wr_row)
   );

   // payloads are only read for present slots, which were always written
   always_ff @(posedge clock) begin
      if (pay_ctl.wr_en) begin
         pay_mem[pay_addr] <= pay_wr_data;
      end
      if (pay_ctl.rd_en) begin
         pay_rd_ff <= pay_mem[pay_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= finish.done;
      end
   end

   // miss and non-next actions report all zero
   always_ff @(posedge clock) begin
      if (finish.done) begin
         rsp_found_ff   <= finish.found;
         rsp_slot_ff    <= finish.found ? SLOT_FIELD_BITS'(finish_slot) : '0;
         rsp_payload_ff <= finish.found ? PAY_FIELD_BITS'(pay_rd_ff) : '0;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_ready_slot    = rsp_slot_ff;
   assign rsp_ready_payload = rsp_payload_ff;

endmodule : dependency_ready_scheduler
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for dependency_ready_scheduler. A shadow copy of the
// dependency graph predicts each dispatch response, and every strobed
// response is checked in order against it. A short directed test is followed
// by random build, dispatch and retire episodes under changing request gaps.
// -----------------------------------------------------------------------------
module testbench;
   import drs_pkg::*;

   localparam int NODES       = NODE_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 2 * NODES + 8;   // worst case: remove or full scan
   localparam int PRINT_LIMIT = 40;

   // one response of the block
   typedef struct packed {
      logic                       found;
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic [PAY_FIELD_BITS-1:0]  payload;
   } dispatch_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [ACTION_BITS-1:0]     req_action;
   logic [SLOT_FIELD_BITS-1:0] req_node_slot;
   logic [SLOT_FIELD_BITS-1:0] req_dependent_slot;
   logic [PAY_FIELD_BITS-1:0]  req_node_payload;
   logic [PAY_FIELD_BITS-1:0]  req_dependent_payload;
   logic                       rsp_strobe;
   logic                       rsp_found;
   logic [SLOT_FIELD_BITS-1:0] rsp_ready_slot;
   logic [PAY_FIELD_BITS-1:0]  rsp_ready_payload;

   // shadow graph: what the block should hold
   logic [NODES-1:0]          present_mask;
   logic [NODES-1:0]          handed_mask;
   logic [NODES-1:0]          waits_on_row [NODES];
   logic [PAY_FIELD_BITS-1:0] stored_payload [NODES];

   dispatch_type pending_dispatch[$];   // responses still owed by the block
   dispatch_type head;

   int error_count;
   int items_sent;
   int responses_seen;
   int hits_seen;
   int cycle_count;
   int gap_pct;                       // chance in 100 of a request gap

   dependency_ready_scheduler dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_node_slot         (req_node_slot),
      .req_dependent_slot    (req_dependent_slot),
      .req_node_payload      (req_node_payload),
      .req_dependent_payload (req_dependent_payload),
      .rsp_strobe            (rsp_strobe),
      .rsp_found             (rsp_found),
      .rsp_ready_slot        (rsp_ready_slot),
      .rsp_ready_payload     (rsp_ready_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or missing response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_dispatch.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want,
                  cycle_count);
      error_count++;
   endtask

   // Update the shadow graph for one accepted transfer and return the
   // response it should produce. Only a next transfer can find a node.
   function automatic dispatch_type apply_action(action_type act,
                                                 logic [SLOT_FIELD_BITS-1:0] s,
                                                 logic [SLOT_FIELD_BITS-1:0] d,
                                                 logic [PAY_FIELD_BITS-1:0] sp,
                                                 logic [PAY_FIELD_BITS-1:0] dp);
      dispatch_type r;
      logic         hit;
      r   = '0;
      hit = 1'b0;
      case (act)
         ACT_ADD_NODE: begin
            stored_payload[s] = sp;
            present_mask[s]   = 1'b1;
         end
         ACT_ADD_EDGE: begin
            // dependent payload written last: wins on a self edge
            stored_payload[s]  = sp;
            stored_payload[d]  = dp;
            present_mask[s]    = 1'b1;
            present_mask[d]    = 1'b1;
            waits_on_row[d][s] = 1'b1;
         end
         ACT_NEXT: begin
            // lowest present, not handed out, nothing pending
            for (int i = 0; i < NODES; i++) begin
               if (!hit && present_mask[i] && !handed_mask[i] && waits_on_row[i] == '0) begin
                  hit            = 1'b1;
                  handed_mask[i] = 1'b1;
                  r.found        = 1'b1;
                  r.slot         = SLOT_FIELD_BITS'(i);
                  r.payload      = stored_payload[i];
               end
            end
         end
         default: begin
            // remove: release dependents, drop own waits, free the slot
            for (int i = 0; i < NODES; i++)
               waits_on_row[i][s] = 1'b0;
            waits_on_row[s] = '0;
            present_mask[s] = 1'b0;
            handed_mask[s]  = 1'b0;
         end
      endcase
      return r;
   endfunction

   // Drive one request, hold it until the transfer, then log its prediction.
   // start stays high on return so back-to-back requests need no gap.
   task automatic send_item(action_type act, logic [SLOT_FIELD_BITS-1:0] s,
                            logic [SLOT_FIELD_BITS-1:0] d,
                            logic [PAY_FIELD_BITS-1:0] sp,
                            logic [PAY_FIELD_BITS-1:0] dp, output dispatch_type want);
      if ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start                 = 1'b1;
      req_action            = act;
      req_node_slot         = s;
      req_dependent_slot    = d;
      req_node_payload      = sp;
      req_dependent_payload = dp;
      do
         @(posedge clock);
      while (busy);
      want = apply_action(act, s, d, sp, dp);
      pending_dispatch.insert(pending_dispatch.size(), want);
      items_sent++;
   endtask

   task automatic send_random_item();
      dispatch_type r;
      send_item(action_type'($urandom_range(3)), 4'($urandom), 4'($urandom),
                $urandom, $urandom, r);
   endtask

   // Drop start, wait for every owed response, then let the block settle.
   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (pending_dispatch.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Random slot from a mask; any slot when the mask is empty.
   function automatic logic [SLOT_FIELD_BITS-1:0] pick_slot(logic [NODES-1:0] mask);
      int offset;
      int j;
      offset = $urandom_range(NODES - 1);
      if (mask == '0)
         return SLOT_FIELD_BITS'(offset);
      for (int k = 0; k < NODES; k++) begin
         j = (offset + k) % NODES;
         if (mask[j])
            return SLOT_FIELD_BITS'(j);
      end
      return '0;
   endfunction

   // Response check: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         responses_seen++;
         if (pending_dispatch.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_ready_slot, 0);
         end else begin
            head = pending_dispatch.pop_front();
            if (head.found)
               hits_seen++;
            if (rsp_found !== head.found)
               report_mismatch("found", rsp_found, head.found);
            if (rsp_ready_slot !== head.slot)
               report_mismatch("ready_slot", rsp_ready_slot, head.slot);
            if (rsp_ready_payload !== head.payload)
               report_mismatch("ready_payload", rsp_ready_payload, head.payload);
         end
      end
   end

   // Directed cases: empty scan, field extremes, every action, self edge,
   // re-adding a handed-out node, removing an absent slot, a two-node cycle.
   task automatic test_directed();
      dispatch_type r;
      send_item(ACT_NEXT,     4'd9,  4'd3,  $urandom,     $urandom,     r); // nothing ready
      send_item(ACT_REMOVE,   4'd5,  4'd15, $urandom,     $urandom,     r); // absent slot
      send_item(ACT_ADD_NODE, 4'd0,  4'd15, 32'h0,        32'hFFFFFFFF, r);
      send_item(ACT_ADD_NODE, 4'd15, 4'd0,  32'hFFFFFFFF, 32'h0,        r);
      send_item(ACT_ADD_EDGE, 4'd15, 4'd0,  32'h12345678, 32'hA5A5A5A5, r);
      send_item(ACT_NEXT,     4'd0,  4'd0,  32'h0,        32'h0,        r); // slot 15
      send_item(ACT_NEXT,     4'd15, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, r); // 0 blocked
      send_item(ACT_ADD_NODE, 4'd15, 4'd2,  32'h5A5A5A5A, $urandom,     r); // keeps mark
      send_item(ACT_NEXT,     4'd1,  4'd1,  $urandom,     $urandom,     r);
      send_item(ACT_REMOVE,   4'd15, 4'd7,  $urandom,     $urandom,     r); // frees 0
      send_item(ACT_NEXT,     4'd2,  4'd2,  $urandom,     $urandom,     r); // slot 0
      send_item(ACT_ADD_EDGE, 4'd7,  4'd7,  32'h0F0F0F0F, 32'hF0F0F0F0, r); // self edge
      send_item(ACT_NEXT,     4'd3,  4'd3,  $urandom,     $urandom,     r); // none
      send_item(ACT_REMOVE,   4'd7,  4'd7,  $urandom,     $urandom,     r);
      send_item(ACT_ADD_NODE, 4'd7,  4'd8,  32'hFFFFFFFF, $urandom,     r);
      send_item(ACT_NEXT,     4'd4,  4'd4,  $urandom,     $urandom,     r); // slot 7
      send_item(ACT_REMOVE,   4'd0,  4'd1,  $urandom,     $urandom,     r);
      send_item(ACT_REMOVE,   4'd7,  4'd1,  $urandom,     $urandom,     r);
      send_item(ACT_ADD_EDGE, 4'd3,  4'd12, 32'h00000001, 32'h80000000, r);
      send_item(ACT_ADD_EDGE, 4'd12, 4'd3,  32'h7FFFFFFF, 32'hFFFFFFFE, r); // cycle
      send_item(ACT_NEXT,     4'd5,  4'd5,  $urandom,     $urandom,     r); // none
      send_item(ACT_REMOVE,   4'd3,  4'd10, $urandom,     $urandom,     r);
      send_item(ACT_NEXT,     4'd6,  4'd6,  $urandom,     $urandom,     r); // slot 12
      send_item(ACT_REMOVE,   4'd12, 4'd5,  $urandom,     $urandom,     r);
      wait_quiet();
   endtask

   // One episode: build a graph (mostly acyclic), then dispatch and retire
   // nodes as a worker pool would, with some noise transfers mixed in.
   task automatic run_graph_episode();
      dispatch_type               r;
      logic [SLOT_FIELD_BITS-1:0] s;
      logic [SLOT_FIELD_BITS-1:0] d;
      logic [SLOT_FIELD_BITS-1:0] t;
      int                         misses;
      int                         rounds;
      repeat ($urandom_range(2, 10)) begin
         if ($urandom_range(99) < 10)
            send_random_item();
         send_item(ACT_ADD_NODE, 4'($urandom), 4'($urandom), $urandom, $urandom, r);
      end
      repeat ($urandom_range(0, 10)) begin
         s = pick_slot(present_mask);
         d = pick_slot(present_mask);
         // lower slot as source keeps most graphs acyclic
         if (s > d && $urandom_range(99) < 85) begin
            t = s;
            s = d;
            d = t;
         end
         if ($urandom_range(99) < 10)
            d = 4'($urandom);
         send_item(ACT_ADD_EDGE, s, d, $urandom, $urandom, r);
      end
      misses = 0;
      rounds = 0;
      while (misses < 2 && rounds < 40) begin
         rounds++;
         if ($urandom_range(99) < 8)
            send_random_item();
         send_item(ACT_NEXT, 4'($urandom), 4'($urandom), $urandom, $urandom, r);
         if (r.found) begin
            if ($urandom_range(99) < 80)
               send_item(ACT_REMOVE, r.slot, 4'($urandom), $urandom, $urandom, r);
         end else begin
            misses++;
            // break a stall: retire something handed out, or anything present
            if (handed_mask != '0)
               s = pick_slot(handed_mask);
            else
               s = pick_slot(present_mask);
            send_item(ACT_REMOVE, s, 4'($urandom), $urandom, $urandom, r);
         end
      end
      repeat ($urandom_range(0, 4))
         send_item(ACT_REMOVE, pick_slot(present_mask), 4'($urandom), $urandom,
                   $urandom, r);
   endtask

   task automatic test_random_phase(int gap, int target);
      gap_pct = gap;
      while (items_sent < target)
         run_graph_episode();
      wait_quiet();
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_action            = ACT_ADD_NODE;
      req_node_slot         = '0;
      req_dependent_slot    = '0;
      req_node_payload      = '0;
      req_dependent_payload = '0;
      present_mask          = '0;
      handed_mask           = '0;
      for (int i = 0; i < NODES; i++) begin
         waits_on_row[i]   = '0;
         stored_payload[i] = '0;
      end
      error_count    = 0;
      items_sent     = 0;
      responses_seen = 0;
      hits_seen      = 0;
      cycle_count    = 0;
      gap_pct        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_phase(7, 400);
      test_random_phase(69, 750);
      test_random_phase(0, 1125);

      $display("covered %0d transfers, %0d responses checked, %0d dispatches found",
               items_sent, responses_seen, hits_seen);
      $display("actions: add node, add edge, next, remove; gaps 7%%, 69%%, none");
      if (error_count == 0 && pending_dispatch.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d responses missing", error_count,
                  pending_dispatch.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/drs_pkg.sv
design/drs_deps.sv
design/drs_ctrl.sv
design/dependency_ready_scheduler.sv
tb/testbench.sv
